[rtl/core/assert_macros.svh]
// Assertion macros shared by the placer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/ssp_pkg.sv]
// Types and constants of the section-to-segment placer.
`timescale 1ns / 1ps
package ssp_pkg;

	localparam int unsigned MAX_SEGMENTS_DEF = 4;
	localparam int unsigned WORD_W           = 32;
	localparam int unsigned IN_TDATA_W       = 72;
	localparam int unsigned OUT_TDATA_W      = 104;

	localparam logic [WORD_W-1:0] EXEC_BASE       = 32'h0000_1000;
	localparam logic [WORD_W-1:0] DATA_BASE_START = 32'h0000_2000;
	localparam logic [WORD_W-1:0] DATA_BASE_STEP  = 32'h0000_1000;

	// segment flag bits
	localparam int unsigned FLAG_EXEC = 0;
	localparam int unsigned FLAG_WRITE = 1;
	localparam int unsigned FLAG_READ = 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_PAD,
		ST_DIV,
		ST_FIX,
		ST_GROW,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] dividend;
		logic [WORD_W-1:0] divisor;
	} rem_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [WORD_W-1:0] rem;
	} rem_rsp_t;

endpackage

[rtl/core/ssp_rem_unit.sv]
// Restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps
module ssp_rem_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  ssp_pkg::rem_req_t req,
	output ssp_pkg::rem_rsp_t rsp
);
	import ssp_pkg::*;

	localparam int unsigned STEP_W = $clog2(WORD_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] num_q;
	logic [WORD_W-1:0] den_q;

	logic [WORD_W:0] trial;
	logic [WORD_W:0] diff;
	logic            fits;

	assign trial = {rem_q, num_q[WORD_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !req.start && (step_q == STEP_W'(WORD_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(WORD_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			num_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so the top bit drops
			rem_q <= fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
			num_q <= {num_q[WORD_W-2:0], 1'b0};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

[rtl/core/section_to_segment_placer.sv]
// Top level: segment table, sequencer and result register of the placer.
// An accepted beat passes the search, pad, grow and result states; when alignment is
// above 1, the 32-step remainder unit divides and a fix state runs between pad and grow.
// s_tready is high only while the sequencer is idle, so no new beat is taken until
// the result of the last one is loaded into the result register.
// Reset (arst_n low): empty table, data base 0x2000, no result pending.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module section_to_segment_placer #(
	parameter int unsigned MAX_SEGMENTS = ssp_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// sec_writable, sec_executable, sec_has_file_data, sec_size[31:0], sec_alignment[31:0]
	input  logic [ssp_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// segment_index[1:0], segment_created, segment_flags[2:0], section_offset[31:0],
	// section_address[31:0], pad_bytes[31:0]
	output logic [ssp_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import ssp_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int unsigned IDX_W = $clog2(MAX_SEGMENTS);

	state_t state_q, state_d;

	// segment table, read and written at ptr only
	logic [2:0]        perm_q [MAX_SEGMENTS];
	logic [WORD_W-1:0] base_q [MAX_SEGMENTS];
	logic [WORD_W-1:0] fsize_q [MAX_SEGMENTS];
	logic [WORD_W-1:0] msize_q [MAX_SEGMENTS];

	logic [CNT_W-1:0]  count_q;
	logic [WORD_W-1:0] next_base_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [IDX_W-1:0]  ptr_idx;

	logic [2:0]        flags_q;
	logic              fdata_q;
	logic [WORD_W-1:0] size_q;
	logic [WORD_W-1:0] align_q;
	logic              created_q;
	logic [WORD_W-1:0] pad_q;
	logic [WORD_W-1:0] grow_q;
	logic [WORD_W-1:0] at_pad_q;

	logic              m_tvalid_q;
	logic [1:0]        out_idx_q;
	logic              out_created_q;
	logic [2:0]        out_flags_q;
	logic [WORD_W-1:0] out_offset_q;
	logic [WORD_W-1:0] out_addr_q;
	logic [WORD_W-1:0] out_pad_q;

	rem_req_t rem_req;
	rem_rsp_t rem_rsp;

	logic              in_range;
	logic              hit;
	logic              can_create;
	logic              align_gt1;
	logic              accept;
	logic              out_load;
	logic [WORD_W-1:0] cur_msize;
	logic [WORD_W:0]   pad_end;

	ssp_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	assign ptr_idx    = ptr_q[IDX_W-1:0];
	assign cur_msize  = msize_q[ptr_idx];
	assign in_range   = ptr_q < count_q;
	assign hit        = in_range && (perm_q[ptr_idx] == flags_q);
	assign can_create = count_q < CNT_W'(MAX_SEGMENTS);
	assign align_gt1  = |align_q[WORD_W-1:1];
	assign pad_end    = {1'b0, cur_msize} + {1'b0, pad_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_SEARCH;
			ST_SEARCH: if (hit || !in_range) state_d = ST_PAD;
			ST_PAD:    state_d = align_gt1 ? ST_DIV : ST_GROW;
			ST_DIV:    if (rem_rsp.done) state_d = ST_FIX;
			ST_FIX:    state_d = ST_GROW;
			ST_GROW:   state_d = ST_RESULT;
			ST_RESULT: if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready         = 1'b0;
		out_load         = 1'b0;
		rem_req.start    = 1'b0;
		rem_req.dividend = cur_msize;
		rem_req.divisor  = align_q;
		unique case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_PAD:    rem_req.start = align_gt1;
			ST_RESULT: out_load = !m_tvalid_q || m_tready;
			default:   ;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			next_base_q <= DATA_BASE_START;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SEARCH && !in_range && can_create) begin
				count_q <= count_q + 1'b1;
				if (!flags_q[FLAG_EXEC])
					next_base_q <= next_base_q + DATA_BASE_STEP;
			end
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// payload and table, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			flags_q   <= {1'b1, s_tdata[0], s_tdata[1]};
			fdata_q   <= s_tdata[2];
			size_q    <= s_tdata[34:3];
			align_q   <= s_tdata[66:35];
			ptr_q     <= '0;
			created_q <= 1'b0;
		end
		if (state_q == ST_SEARCH) begin
			if (in_range && !hit) begin
				ptr_q <= ptr_q + 1'b1;
			end else if (!in_range) begin
				if (can_create) begin
					perm_q[ptr_idx]  <= flags_q;
					base_q[ptr_idx]  <= flags_q[FLAG_EXEC] ? EXEC_BASE : next_base_q;
					fsize_q[ptr_idx] <= '0;
					msize_q[ptr_idx] <= '0;
					created_q        <= 1'b1;
				end else begin
					// table full: fall back to segment 0
					ptr_q <= '0;
				end
			end
		end
		if (state_q == ST_PAD)
			pad_q <= '0;
		if (state_q == ST_DIV && rem_rsp.done)
			pad_q <= (rem_rsp.rem == '0) ? '0 : align_q - rem_rsp.rem;
		// next multiple past the top of the space: stop at the wrap to 0
		if (state_q == ST_FIX && pad_end[WORD_W])
			pad_q <= '0 - cur_msize;
		if (state_q == ST_GROW) begin
			grow_q   <= size_q + pad_q;
			at_pad_q <= pad_end[WORD_W-1:0];
		end
		if (out_load) begin
			out_idx_q        <= ptr_q[1:0];
			out_created_q    <= created_q;
			out_flags_q      <= flags_q;
			out_offset_q     <= base_q[ptr_idx] + fsize_q[ptr_idx];
			out_addr_q       <= base_q[ptr_idx] + at_pad_q;
			out_pad_q        <= pad_q;
			msize_q[ptr_idx] <= cur_msize + grow_q;
			if (fdata_q)
				fsize_q[ptr_idx] <= fsize_q[ptr_idx] + grow_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_pad_q, out_addr_q, out_offset_q,
	                   out_flags_q, out_created_q, out_idx_q};

	`ASSERT_CLK(a_count_max, clk, arst_n, count_q <= CNT_W'(MAX_SEGMENTS), "segment count beyond table")
	`ASSERT_CLK(a_rem_start_idle, clk, arst_n, rem_req.start |-> !rem_rsp.busy, "remainder unit restarted while busy")
	`ASSERT_CLK(a_hit_keeps_count, clk, arst_n, (state_q == ST_SEARCH && hit) |=> $stable(count_q), "segment created on a table hit")
	`ASSERT_CLK(a_valid_from_result, clk, arst_n, $rose(m_tvalid_q) |-> $past(state_q) == ST_RESULT, "result raised outside result state")

endmodule
